FILE: rtl/core/fxalu_pkg.sv
// fxalu_pkg: operation codes, fixed widths and the structs shared by the
// fixed-point alu pipeline. no dependencies.
package fxalu_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned DivQBits = 33;  // quotient bits resolved by the divider

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MIN  = 4'd4,
    OP_MAX  = 4'd5,
    OP_INC  = 4'd6,
    OP_DEC  = 4'd7,
    OP_INT  = 4'd8,
    OP_FROM = 4'd9
  } fx_op_e;

  localparam logic [DataW-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] SatMin = 32'h8000_0000;

  // per-item data that rides alongside the divider
  typedef struct packed {
    logic [3:0]       op;
    logic [DataW-1:0] res;
    logic             ovf;
    logic             gt;
    logic             lt;
    logic             eq;
  } fx_side_t;

  typedef struct packed {
    logic dov;    // quotient already at or beyond 2^33
    logic dz;
    logic neg;
    logic a_neg;
  } fx_div_ctl_t;

  typedef struct packed {
    fx_div_ctl_t          ctl;
    logic [DivQBits-1:0]  quo;
    logic [DataW-1:0]     rem;
    logic [DataW-1:0]     den;
  } fx_div_out_t;

endpackage

FILE: rtl/core/fxalu_mul.sv
// fxalu_mul: two-stage signed multiply with round half away from zero and
// saturation. depends on fxalu_pkg.
module fxalu_mul import fxalu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk_i,
  input  logic [1:0]       en_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output logic [DataW-1:0] res_o,
  output logic             ovf_o
);

  localparam logic [63:0] Half   = 64'(1) << (FRAC_BITS - 1);
  localparam logic [63:0] HalfM1 = Half - 64'(1);

  logic signed [63:0] prod_q;
  logic signed [63:0] rnd_sum;
  logic signed [63:0] shifted;
  logic [DataW-1:0]   res_d;
  logic               ovf_d;
  logic [DataW-1:0]   res_q;
  logic               ovf_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= $signed(a_i) * $signed(b_i);
    end
  end

  // negative products floor after adding half minus one, which mirrors rounding away from zero
  always_comb begin
    rnd_sum = prod_q + $signed(prod_q[63] ? HalfM1 : Half);
    shifted = rnd_sum >>> FRAC_BITS;
    ovf_d   = 1'b0;
    res_d   = shifted[DataW-1:0];
    if (shifted[63:31] != {33{shifted[63]}}) begin
      ovf_d = 1'b1;
      res_d = shifted[63] ? SatMin : SatMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
    end
  end

  assign res_o = res_q;
  assign ovf_o = ovf_q;

endmodule

FILE: rtl/core/fxalu_div.sv
// fxalu_div: pipelined restoring divider, one quotient bit per stage, on the
// magnitudes of (a << FRAC_BITS) and b. depends on fxalu_pkg.
module fxalu_div import fxalu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic              clk_i,
  input  logic [DivQBits:0] en_i,
  input  logic [DataW-1:0]  a_i,
  input  logic [DataW-1:0]  b_i,
  output fx_div_out_t       div_o
);

  localparam int unsigned NumW = DataW + FRAC_BITS;

  logic [DataW-1:0]    a_mag;
  logic [DataW-1:0]    b_mag;
  logic [NumW-1:0]     num;
  logic [NumW-1:0]     hi;
  fx_div_ctl_t         ctl_d;

  logic [DataW-1:0]    rem_q [DivQBits+1];
  logic [DivQBits-1:0] low_q [DivQBits+1];
  logic [DivQBits-1:0] quo_q [DivQBits+1];
  logic [DataW-1:0]    den_q [DivQBits+1];
  fx_div_ctl_t         ctl_q [DivQBits+1];

  always_comb begin
    a_mag     = a_i[DataW-1] ? (~a_i + 32'd1) : a_i;
    b_mag     = b_i[DataW-1] ? (~b_i + 32'd1) : b_i;
    num       = {a_mag, {FRAC_BITS{1'b0}}};
    hi        = num >> DivQBits;
    ctl_d.dov = hi >= NumW'(b_mag);
    ctl_d.dz  = (b_i == '0);
    ctl_d.neg = a_i[DataW-1] ^ b_i[DataW-1];
    ctl_d.a_neg = a_i[DataW-1];
  end

  // top part of the numerator seeds the remainder, the low 33 bits are shifted in
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= hi[DataW-1:0];
      low_q[0] <= num[DivQBits-1:0];
      quo_q[0] <= '0;
      den_q[0] <= b_mag;
      ctl_q[0] <= ctl_d;
    end
  end

  for (genvar j = 0; j < DivQBits; j++) begin : g_step
    logic [DataW:0]   trial;
    logic [DataW:0]   diff;
    logic             ge;
    logic [DataW-1:0] rem_d;

    always_comb begin
      trial = {rem_q[j], low_q[j][DivQBits-1]};
      diff  = trial - {1'b0, den_q[j]};
      ge    = trial >= {1'b0, den_q[j]};
      rem_d = ge ? diff[DataW-1:0] : trial[DataW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j+1]) begin
        rem_q[j+1] <= rem_d;
        low_q[j+1] <= {low_q[j][DivQBits-2:0], 1'b0};
        quo_q[j+1] <= {quo_q[j][DivQBits-2:0], ge};
        den_q[j+1] <= den_q[j];
        ctl_q[j+1] <= ctl_q[j];
      end
    end
  end

  assign div_o.ctl = ctl_q[DivQBits];
  assign div_o.quo = quo_q[DivQBits];
  assign div_o.rem = rem_q[DivQBits];
  assign div_o.den = den_q[DivQBits];

endmodule

FILE: rtl/core/fixed_point_q24_8_alu.sv
// fixed_point_q24_8_alu: top level of the signed fixed-point alu pipeline.
// depends on fxalu_pkg, fxalu_mul and fxalu_div.
//
// usage:
//   the slave channel takes one request per handshake: tuser holds the
//   operation code, tdata holds operand a (low word) and operand b (high word).
//   the master channel returns exactly one result per request, in order:
//   the 32-bit value followed by the greater, less, equal, overflow and
//   divide-by-zero flags.
//   the result shows on m_axis_tvalid_o once it has passed the 36 register
//   stages, most of them in the divider, which resolves one of its 33
//   quotient bits per stage. all operations share these stages.
//   throughput is one request per cycle while the receiver does not stall.
//   every stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles are squeezed out and the input stays
//   ready while any stage is free. when the receiver stalls, the result holds
//   on the master channel and the pipeline fills behind it; nothing is dropped
//   or repeated. reset empties the pipeline (valid bits clear); data is not reset.
module fixed_point_q24_8_alu import fxalu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  s_axis_tuser_i,   // req_type [3:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_value [31:0], a_greater [32], a_less [33], a_equal [34],
  // overflowed [35], divide_by_zero [36], zero [39:37]
  output logic [39:0] m_axis_tdata_o
);

  localparam int unsigned NStg = DivQBits + 3;
  localparam int unsigned Last = NStg - 1;

  logic [NStg:0]     en;
  logic [NStg-1:0]   vld_q;

  logic [3:0]        op0_q;
  logic [DataW-1:0]  a0_q;
  logic [DataW-1:0]  b0_q;

  fx_side_t          side_d;
  fx_side_t          side3_d;
  fx_side_t          side_q [DivQBits+2];

  logic [DataW-1:0]  mul_res;
  logic              mul_ovf;
  fx_div_out_t       div_out;

  logic [DataW-1:0]  res_d;
  logic              ovf_d;
  logic              dz_d;
  logic [DataW-1:0]  res_q;
  logic              gt_q;
  logic              lt_q;
  logic              eq_q;
  logic              ovf_q;
  logic              dz_q;

  // a stage loads when it is empty or its successor moves
  assign en[NStg] = m_axis_tready_i;
  for (genvar k = 0; k < NStg; k++) begin : g_en
    assign en[k] = ~vld_q[k] | en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      op0_q <= s_axis_tuser_i;
      a0_q  <= s_axis_tdata_i[31:0];
      b0_q  <= s_axis_tdata_i[63:32];
    end
  end

  // combinational operations on the input stage and compare flags
  always_comb begin
    logic signed [DataW:0]           sum;
    logic signed [DataW:0]           dif;
    logic signed [DataW+FRAC_BITS-1:0] scaled;
    sum    = {a0_q[DataW-1], a0_q} + {b0_q[DataW-1], b0_q};
    dif    = {a0_q[DataW-1], a0_q} - {b0_q[DataW-1], b0_q};
    scaled = {a0_q, {FRAC_BITS{1'b0}}};
    side_d.op  = op0_q;
    side_d.gt  = $signed(a0_q) > $signed(b0_q);
    side_d.lt  = $signed(a0_q) < $signed(b0_q);
    side_d.eq  = (a0_q == b0_q);
    side_d.res = '0;
    side_d.ovf = 1'b0;
    case (op0_q)
      OP_ADD: begin
        side_d.ovf = sum[DataW] ^ sum[DataW-1];
        side_d.res = side_d.ovf ? (sum[DataW] ? SatMin : SatMax) : sum[DataW-1:0];
      end
      OP_SUB: begin
        side_d.ovf = dif[DataW] ^ dif[DataW-1];
        side_d.res = side_d.ovf ? (dif[DataW] ? SatMin : SatMax) : dif[DataW-1:0];
      end
      OP_MIN: side_d.res = side_d.gt ? b0_q : a0_q;
      OP_MAX: side_d.res = side_d.lt ? b0_q : a0_q;
      OP_INC: begin
        side_d.ovf = (a0_q == SatMax);
        side_d.res = side_d.ovf ? SatMax : a0_q + 32'd1;
      end
      OP_DEC: begin
        side_d.ovf = (a0_q == SatMin);
        side_d.res = side_d.ovf ? SatMin : a0_q - 32'd1;
      end
      OP_INT: side_d.res = $signed(a0_q) >>> FRAC_BITS;
      OP_FROM: begin
        side_d.ovf = scaled[DataW+FRAC_BITS-1:DataW-1] != {(FRAC_BITS+1){a0_q[DataW-1]}};
        side_d.res = side_d.ovf ? (a0_q[DataW-1] ? SatMin : SatMax)
                                : scaled[DataW-1:0];
      end
      default: side_d.res = '0;
    endcase
  end

  always_comb begin
    side3_d = side_q[2];
    if (side_q[2].op == OP_MUL) begin
      side3_d.res = mul_res;
      side3_d.ovf = mul_ovf;
    end
  end

  // side line runs in parallel with the divider; the multiply result joins at stage 3
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      side_q[1] <= side_d;
    end
    if (en[2]) begin
      side_q[2] <= side_q[1];
    end
    if (en[3]) begin
      side_q[3] <= side3_d;
    end
    for (int k = 4; k <= DivQBits + 1; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  fxalu_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (en[2:1]),
    .a_i   (a0_q),
    .b_i   (b0_q),
    .res_o (mul_res),
    .ovf_o (mul_ovf)
  );

  fxalu_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en[DivQBits+1:1]),
    .a_i   (a0_q),
    .b_i   (b0_q),
    .div_o (div_out)
  );

  // quotient rounding, saturation and final select
  always_comb begin
    logic            rnd;
    logic [DataW+1:0] mag;
    fx_side_t        sd;
    sd    = side_q[DivQBits+1];
    rnd   = {div_out.rem, 1'b0} >= {1'b0, div_out.den};
    mag   = {1'b0, div_out.quo} + 34'(rnd);
    res_d = sd.res;
    ovf_d = sd.ovf;
    dz_d  = 1'b0;
    if (sd.op == OP_DIV) begin
      if (div_out.ctl.dz) begin
        dz_d  = 1'b1;
        ovf_d = 1'b0;
        res_d = div_out.ctl.a_neg ? SatMin : SatMax;
      end else if (div_out.ctl.neg) begin
        ovf_d = div_out.ctl.dov || (mag > 34'h0_8000_0000);
        res_d = ovf_d ? SatMin : (~mag[DataW-1:0] + 32'd1);
      end else begin
        ovf_d = div_out.ctl.dov || (mag > 34'h0_7FFF_FFFF);
        res_d = ovf_d ? SatMax : mag[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[Last]) begin
      res_q <= res_d;
      gt_q  <= side_q[DivQBits+1].gt;
      lt_q  <= side_q[DivQBits+1].lt;
      eq_q  <= side_q[DivQBits+1].eq;
      ovf_q <= ovf_d;
      dz_q  <= dz_d;
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[Last];
  assign m_axis_tdata_o  = {3'b000, dz_q, ovf_q, eq_q, lt_q, gt_q, res_q};

  a_cmp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot({gt_q, lt_q, eq_q}))
    else $error("compare flags not exclusive");

  a_dz_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && dz_q |-> !ovf_q)
    else $error("divide by zero raised overflow");

  a_dz_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && dz_q |-> (res_q == SatMax) || (res_q == SatMin))
    else $error("divide by zero result not saturated");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ovf_q |-> (res_q == SatMax) || (res_q == SatMin))
    else $error("overflow result not saturated");

endmodule
